// File: rtl/core/sorted_timer_queue_macros.svh
// Assertion helpers for the RTL, included by sorted_timer_queue.sv.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/stq_pkg.sv
package stq_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NF    = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int MAX_RESULTS = 16;
  localparam int NW          = 5;

  typedef struct packed {
    logic [63:0] due;
    logic [31:0] period;
    logic        reload;
    logic [15:0] ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/stq_ram.sv
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/sorted_timer_queue.sv
// Operation: an add walks from the tail, reading each entry and shifting it up while it is due
// later than the new timer, then writes the new one (a full queue answers at once); a delete
// searches from slot 0, then shifts the later entries down; a tick checks the head, removes each
// expired entry by shifting, reinserts it if periodic, and flushes the last report at the end.
// Concurrency: one transaction at a time; the walks step through the entry memory in turn.
// Reset (synchronous, rst_n low): queue empty, time zero, next id one, no result pending.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // delay_ms[31:0], is_periodic[32], target_id[48:33], zero pad
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // tmr_id[15:0], status[17:16], zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);
  import stq_pkg::*;
  `include "sorted_timer_queue_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_ANS, S_TRD, S_TCHK, S_TFIN, S_RRD, S_RWR, S_IRD, S_ICHK, S_DRD, S_DCHK
  } state_t;

  state_t        state_r;
  func_t         op_r;
  logic [63:0]   now_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] ptr_r;
  logic [15:0]   next_id_r;
  logic [NW-1:0] n_r;
  entry_t        ins_r;
  logic [15:0]   target_r;
  logic          pend_v_r;
  logic [15:0]   pend_id_r;
  logic [1:0]    ans_kind_r;
  logic [15:0]   ans_id_r;
  logic [1:0]    ans_stat_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_id_r;
  logic [1:0]  out_stat_r;
  logic        out_last_r;

  // Memory port signals
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rd_data;
  logic [ENTRY_W-1:0] rd_raw;

  logic        slot_free;
  logic        emit;
  logic        in_acc;
  logic [31:0] step;
  logic [15:0] id_inc;
  logic [CW-1:0] ptr_inc;

  func_t       in_func;
  logic [31:0] in_delay;
  logic        in_per;
  logic [15:0] in_target;

  assign in_func   = func_t'(in_tuser);
  assign in_delay  = in_tdata[31:0];
  assign in_per    = in_tdata[32];
  assign in_target = in_tdata[48:33];

  assign rd_data   = entry_t'(rd_raw);
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign step      = (rd_data.period == 32'd0) ? 32'd1 : rd_data.period;
  assign id_inc    = next_id_r + 16'd1;
  assign ptr_inc   = ptr_r + CW'(1);

  // a new result enters the output register this cycle
  assign emit = slot_free && ((state_r == S_ANS) ||
                ((state_r == S_TCHK) && pend_v_r && (rd_data.due <= now_r)) ||
                ((state_r == S_TFIN) && pend_v_r));

  // Drive the memory from the sequencer state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_data = ins_r;
    unique case (state_r)
      S_TRD: begin
        rd_en = (count_r != '0) && (n_r != NW'(MAX_RESULTS));
      end
      S_RRD: begin
        rd_en   = ptr_inc < count_r;
        rd_addr = ptr_inc[AW-1:0];
      end
      S_RWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_IRD: begin
        if (ptr_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_r - CW'(1));
        end
      end
      S_ICHK: begin
        wr_en = 1'b1;
        if (rd_data.due > ins_r.due) begin
          wr_data = rd_data;
        end
      end
      S_DRD: begin
        rd_en   = ptr_r < count_r;
        rd_addr = ptr_r[AW-1:0];
      end
      default: ;
    endcase
  end

  stq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= FUNC_NONE;
      now_r       <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      next_id_r   <= 16'd1;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the sink takes it, unless a new one replaces it
      if (out_tready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r <= in_func;
            case (in_func)
              FUNC_ADD: begin
                ans_kind_r <= KIND_ADD;
                if (count_r >= DEPTH_C) begin
                  ans_id_r   <= 16'd0;
                  ans_stat_r <= STAT_FULL;
                  state_r    <= S_ANS;
                end else begin
                  ans_id_r      <= next_id_r;
                  ans_stat_r    <= STAT_OK;
                  ins_r.due     <= now_r + {32'd0, in_delay};
                  ins_r.period  <= in_delay;
                  ins_r.reload  <= in_per;
                  ins_r.ident   <= next_id_r;
                  next_id_r     <= (id_inc == 16'd0) ? 16'd1 : id_inc;
                  ptr_r         <= count_r;
                  state_r       <= S_IRD;
                end
              end
              FUNC_DEL: begin
                target_r   <= in_target;
                ans_kind_r <= KIND_DEL;
                ptr_r      <= '0;
                state_r    <= S_DRD;
              end
              FUNC_TICK: begin
                now_r    <= now_r + 64'd1;
                n_r      <= '0;
                pend_v_r <= 1'b0;
                state_r  <= S_TRD;
              end
              default: ;
            endcase
          end
        end
        S_ANS: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= ans_kind_r;
            out_id_r    <= ans_id_r;
            out_stat_r  <= ans_stat_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_TRD: begin
          state_r <= ((count_r != '0) && (n_r != NW'(MAX_RESULTS))) ? S_TCHK : S_TFIN;
        end
        S_TCHK: begin
          if (rd_data.due <= now_r) begin
            if (!pend_v_r || slot_free) begin
              // emit the previous expiry, hold this one until the next is known
              if (pend_v_r) begin
                out_valid_r <= 1'b1;
                out_kind_r  <= KIND_EXPIRE;
                out_id_r    <= pend_id_r;
                out_stat_r  <= STAT_OK;
                out_last_r  <= 1'b0;
              end
              pend_v_r     <= 1'b1;
              pend_id_r    <= rd_data.ident;
              n_r          <= n_r + NW'(1);
              ins_r.due    <= now_r + {32'd0, step};
              ins_r.period <= rd_data.period;
              ins_r.reload <= rd_data.reload;
              ins_r.ident  <= rd_data.ident;
              ptr_r        <= '0;
              state_r      <= S_RRD;
            end
          end else begin
            state_r <= S_TFIN;
          end
        end
        S_TFIN: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_EXPIRE;
            out_id_r    <= pend_id_r;
            out_stat_r  <= STAT_OK;
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_RRD: begin
          if (ptr_inc < count_r) begin
            state_r <= S_RWR;
          end else begin
            count_r <= count_r - CW'(1);
            if (op_r == FUNC_TICK) begin
              if (ins_r.reload) begin
                ptr_r   <= count_r - CW'(1);
                state_r <= S_IRD;
              end else begin
                state_r <= S_TRD;
              end
            end else begin
              ans_id_r   <= target_r;
              ans_stat_r <= STAT_OK;
              state_r    <= S_ANS;
            end
          end
        end
        S_RWR: begin
          ptr_r   <= ptr_inc;
          state_r <= S_RRD;
        end
        S_IRD: begin
          if (ptr_r == '0) begin
            count_r <= count_r + CW'(1);
            state_r <= (op_r == FUNC_TICK) ? S_TRD : S_ANS;
          end else begin
            state_r <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (rd_data.due > ins_r.due) begin
            ptr_r   <= ptr_r - CW'(1);
            state_r <= S_IRD;
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= (op_r == FUNC_TICK) ? S_TRD : S_ANS;
          end
        end
        S_DRD: begin
          if (ptr_r < count_r) begin
            state_r <= S_DCHK;
          end else begin
            ans_id_r   <= 16'd0;
            ans_stat_r <= STAT_NF;
            state_r    <= S_ANS;
          end
        end
        S_DCHK: begin
          if ((target_r != 16'd0) && (rd_data.ident == target_r)) begin
            state_r <= S_RRD;
          end else begin
            ptr_r   <= ptr_inc;
            state_r <= S_DRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_stat_r, out_id_r};

  `STQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C, "queue count overflow")
  `STQ_ASSERT_IMP(a_burst_bound, clk, rst_n, 1'b1, n_r <= NW'(MAX_RESULTS), "tick burst overrun")
  `STQ_ASSERT_NXT(a_full_hold, clk, rst_n, in_acc && (in_func == FUNC_ADD) && (count_r >= DEPTH_C),
    (count_r == $past(count_r)) && (next_id_r == $past(next_id_r)), "full add changed queue")

endmodule
